@@ rtl/core/circle_window_scanline_edges_assert.svh @@
// Assertion macros for the circle window scanline edge block.
// Depends on nothing; the files that check their logic include it.
`ifndef CIRCLE_WINDOW_SCANLINE_EDGES_ASSERT_SVH
`define CIRCLE_WINDOW_SCANLINE_EDGES_ASSERT_SVH
`ifndef SYNTHESIS
`define CWSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWSE_ASSERT(lbl, prop, msg)
`define CWSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/cwse_pkg.sv @@
// Shared constants, types and register codes of the circle window block.
// Depends on nothing.
package cwse_pkg;
  localparam int TABLE_RADIUS = 200;
  localparam int TABLE_DEPTH = 2 * TABLE_RADIUS + 1;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(TABLE_RADIUS + 1);
  localparam int DW = RW + 5;
  localparam int SPAN_W = 10;
  localparam int RAD_W = 10;
  localparam int POS_W = 12;
  localparam int EDGE_W = 13;
  localparam int DIFF_W = 14;
  localparam int DVD_W = 11 + RW;
  localparam int PROD_W = SPAN_W + RAD_W;
  localparam int QS_W = SPAN_W + 1;
  localparam int RCP_S = PROD_W + $clog2(TABLE_RADIUS);
  localparam int RCP_W = PROD_W + 1;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RCP_S) + 64'(TABLE_RADIUS) - 64'd1) / 64'(TABLE_RADIUS);
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(RCP_FULL);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_CENTER_X = 2'd1;
  localparam logic [1:0] REG_CENTER_Y = 2'd2;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [POS_W-1:0] center_x;
    logic [POS_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic [EDGE_W-1:0] base;
    logic [DVD_W-1:0] dvd;
  } item_t;

  typedef struct packed {
    logic we;
    logic [AW-1:0] addr;
    logic [SPAN_W-1:0] left;
    logic [SPAN_W-1:0] right;
  } span_wr_t;
endpackage

@@ rtl/core/cwse_span_build.sv @@
// Midpoint circle sequencer that writes the span table after reset.
// Depends on cwse_pkg.
module cwse_span_build (
  input  logic                clk,
  input  logic                rst_n,
  output cwse_pkg::span_wr_t  wr,
  output logic                ready
);
  localparam logic ST_BUILD = 1'b0;
  localparam logic ST_DONE = 1'b1;
  localparam logic [cwse_pkg::AW-1:0] C = cwse_pkg::AW'(cwse_pkg::TABLE_RADIUS);

  logic state_r, state_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [cwse_pkg::RW-1:0] a_r, a_nxt, b_r, b_nxt, a1;
  logic signed [cwse_pkg::DW-1:0] d_r, d_nxt;

  always_comb begin
    state_nxt = state_r;
    sub_nxt = sub_r;
    a_nxt = a_r;
    b_nxt = b_r;
    d_nxt = d_r;
    a1 = a_r + 1'b1;
    unique case (state_r)
      ST_BUILD: begin
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          if (b_r >= a_r) begin
            a_nxt = a1;
            if (d_r > 0) begin
              b_nxt = b_r - 1'b1;
              d_nxt = cwse_pkg::DW'(d_r + 4 * ($signed({1'b0, a1}) -
                                    $signed({1'b0, b_r - 1'b1})) + 10);
            end else begin
              d_nxt = cwse_pkg::DW'(d_r + 4 * $signed({1'b0, a1}) + 6);
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: ;
      default: state_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BUILD;
      sub_r <= 2'd0;
      a_r <= '0;
      b_r <= cwse_pkg::RW'(cwse_pkg::TABLE_RADIUS);
      d_r <= cwse_pkg::DW'(3 - 2 * cwse_pkg::TABLE_RADIUS);
    end else begin
      state_r <= state_nxt;
      sub_r <= sub_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      d_r <= d_nxt;
    end
  end

  logic [cwse_pkg::AW-1:0] ax, bx;
  assign ax = cwse_pkg::AW'(a_r);
  assign bx = cwse_pkg::AW'(b_r);

  always_comb begin
    wr.we = (state_r == ST_BUILD);
    case (sub_r)
      2'd0: begin
        wr.addr = C + bx;
        wr.left = cwse_pkg::SPAN_W'(C - ax);
        wr.right = cwse_pkg::SPAN_W'(C + ax);
      end
      2'd1: begin
        wr.addr = C - bx;
        wr.left = cwse_pkg::SPAN_W'(C - ax);
        wr.right = cwse_pkg::SPAN_W'(C + ax);
      end
      2'd2: begin
        wr.addr = C + ax;
        wr.left = cwse_pkg::SPAN_W'(C - bx);
        wr.right = cwse_pkg::SPAN_W'(C + bx);
      end
      default: begin
        wr.addr = C - ax;
        wr.left = cwse_pkg::SPAN_W'(C - bx);
        wr.right = cwse_pkg::SPAN_W'(C + bx);
      end
    endcase
  end

  assign ready = (state_r == ST_DONE);
endmodule

@@ rtl/core/cwse_front.sv @@
// Request front end: classify a scanline against the band and form the divide operand.
// Depends on cwse_pkg.
module cwse_front (
  input  logic                     start,
  input  logic [9:0]               scanline,
  input  cwse_pkg::cfg_t           cfg,
  input  logic                     tbl_ready,
  input  logic                     q_full,
  output logic                     push,
  output cwse_pkg::item_t          item,
  output logic                     busy
);
  logic signed [cwse_pkg::DIFF_W-1:0] top, diff, line_s;
  logic [cwse_pkg::DIFF_W-1:0] two_rad;

  assign busy = !tbl_ready || q_full;
  assign push = start && !busy;
  assign line_s = $signed({4'b0, scanline});
  assign top = cwse_pkg::DIFF_W'($signed(cfg.center_y)) -
               $signed({4'b0, cfg.radius});
  assign diff = line_s - top;
  assign two_rad = {3'b0, cfg.radius, 1'b0};

  always_comb begin
    item.en = (cfg.radius != '0) && !diff[cwse_pkg::DIFF_W-1] &&
              (cwse_pkg::DIFF_W'(diff) <= two_rad);
    item.base = cwse_pkg::EDGE_W'($signed(cfg.center_x)) -
                cwse_pkg::EDGE_W'(cfg.radius);
    item.dvd = item.en ? cwse_pkg::DVD_W'(diff[10:0]) *
                         cwse_pkg::DVD_W'(cwse_pkg::TABLE_RADIUS) : '0;
  end
endmodule

@@ rtl/core/cwse_fifo.sv @@
// Short request queue between the front end and the scaling pipeline.
// Depends on cwse_pkg.
module cwse_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cwse_pkg::item_t  din,
  input  logic             pop,
  output cwse_pkg::item_t  dout,
  output logic             empty,
  output logic             full
);
  cwse_pkg::item_t mem_r [0:cwse_pkg::FIFO_DEPTH-1];
  logic [cwse_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [cwse_pkg::FIFO_AW:0] cnt_r, cnt_nxt;
  logic do_pop;

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (cwse_pkg::FIFO_AW+1)'(cwse_pkg::FIFO_DEPTH));
  assign do_pop = pop && !empty;
  assign dout = mem_r[rptr_r];
  assign cnt_nxt = cnt_r + (cwse_pkg::FIFO_AW+1)'(push) - (cwse_pkg::FIFO_AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ rtl/core/cwse_back.sv @@
// Scaling pipeline: row divide, span table lookup, edge scaling by R/TABLE_RADIUS.
// Depends on cwse_pkg and the assertion header.
`include "circle_window_scanline_edges_assert.svh"
module cwse_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  cwse_pkg::item_t           in_item,
  input  logic [cwse_pkg::RAD_W-1:0] radius,
  input  cwse_pkg::span_wr_t        wr,
  input  logic                      tbl_ready,
  output logic                      out_v,
  output logic                      out_en,
  output logic [cwse_pkg::EDGE_W-1:0] out_l,
  output logic [cwse_pkg::EDGE_W-1:0] out_r
);
  localparam int AW = cwse_pkg::AW;

  logic [cwse_pkg::SPAN_W-1:0] left_mem [0:cwse_pkg::TABLE_DEPTH-1];
  logic [cwse_pkg::SPAN_W-1:0] right_mem [0:cwse_pkg::TABLE_DEPTH-1];

  logic                          v_r [0:AW];
  logic                          en_r [0:AW];
  logic [cwse_pkg::EDGE_W-1:0]   base_r [0:AW];
  logic [cwse_pkg::DVD_W-1:0]    rem_r [0:AW];
  logic [AW-1:0]                 q_r [0:AW];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= in_v;
    en_r[0] <= in_item.en;
    base_r[0] <= in_item.base;
    rem_r[0] <= in_item.dvd;
    q_r[0] <= '0;
  end

  genvar i;
  generate
    for (i = 0; i < AW; i++) begin : g_div
      localparam int K = AW - 1 - i;
      logic [cwse_pkg::DVD_W-1:0] trial;
      logic ge;
      assign trial = cwse_pkg::DVD_W'(radius) << K;
      assign ge = rem_r[i] >= trial;
      always_ff @(posedge clk) begin
        if (!rst_n) v_r[i+1] <= 1'b0;
        else v_r[i+1] <= v_r[i];
        en_r[i+1] <= en_r[i];
        base_r[i+1] <= base_r[i];
        rem_r[i+1] <= ge ? rem_r[i] - trial : rem_r[i];
        q_r[i+1] <= q_r[i] | (AW'(ge) << K);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (wr.we) begin
      left_mem[wr.addr] <= wr.left;
      right_mem[wr.addr] <= wr.right;
    end
  end

  logic m_v_r, m_en_r, p_v_r, p_en_r, s_v_r, s_en_r;
  logic [cwse_pkg::EDGE_W-1:0] m_base_r, p_base_r, s_base_r;
  logic [cwse_pkg::SPAN_W-1:0] tl_r, tr_r;
  logic [cwse_pkg::PROD_W-1:0] pl_r, pr_r;
  logic [cwse_pkg::QS_W-1:0] sl_r, sr_r;
  logic [cwse_pkg::PROD_W+cwse_pkg::RCP_W-1:0] ml, mr;

  assign ml = (cwse_pkg::PROD_W+cwse_pkg::RCP_W)'(pl_r) *
              (cwse_pkg::PROD_W+cwse_pkg::RCP_W)'(cwse_pkg::RCP_M);
  assign mr = (cwse_pkg::PROD_W+cwse_pkg::RCP_W)'(pr_r) *
              (cwse_pkg::PROD_W+cwse_pkg::RCP_W)'(cwse_pkg::RCP_M);

  always_ff @(posedge clk) begin
    tl_r <= left_mem[q_r[AW]];
    tr_r <= right_mem[q_r[AW]];
    m_en_r <= en_r[AW];
    m_base_r <= base_r[AW];
    pl_r <= cwse_pkg::PROD_W'(tl_r) * cwse_pkg::PROD_W'(radius);
    pr_r <= cwse_pkg::PROD_W'(tr_r) * cwse_pkg::PROD_W'(radius);
    p_en_r <= m_en_r;
    p_base_r <= m_base_r;
    sl_r <= ml[cwse_pkg::RCP_S +: cwse_pkg::QS_W];
    sr_r <= mr[cwse_pkg::RCP_S +: cwse_pkg::QS_W];
    s_en_r <= p_en_r;
    s_base_r <= p_base_r;
    out_en <= s_en_r;
    out_l <= s_en_r ? s_base_r + cwse_pkg::EDGE_W'(sl_r) : '0;
    out_r <= s_en_r ? s_base_r + cwse_pkg::EDGE_W'(sr_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      out_v <= 1'b0;
    end else begin
      m_v_r <= v_r[AW];
      p_v_r <= m_v_r;
      s_v_r <= p_v_r;
      out_v <= s_v_r;
    end
  end

  `CWSE_ASSERT(a_no_write_after_ready, tbl_ready |-> !wr.we, "span table written after build")
  `CWSE_ASSERT(a_idle_while_build, !tbl_ready |-> !v_r[0], "request entered during build")
  `CWSE_ASSERT(a_row_in_table, v_r[AW] && en_r[AW] |-> q_r[AW] <= AW'(cwse_pkg::TABLE_DEPTH - 1),
    "row outside span table")
endmodule

@@ rtl/core/circle_window_scanline_edges.sv @@
// Top level of the circle window scanline edge block: config registers and wiring.
// Depends on cwse_pkg, cwse_span_build, cwse_front, cwse_fifo, cwse_back.
//
//   port group   handshake          payload
//   request      start / busy       in_scanline
//   result       out_valid          out_window_enabled, out_left_x, out_right_x
//   config       cfg_we             cfg_index, cfg_data
//
// One request per cycle while busy is low; the result passes the request queue, the
// one-bit-per-stage row divider, the table lookup and the two multiply stages.
// After reset the span table is built by the circle sequencer, four table writes
// per circle step; busy is high throughout.
// Reset is synchronous, active low. Results cannot be stalled.
`include "circle_window_scanline_edges_assert.svh"
module circle_window_scanline_edges (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         in_scanline,
  output logic               out_valid,
  output logic               out_window_enabled,
  output logic signed [12:0] out_left_x,
  output logic signed [12:0] out_right_x,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  cwse_pkg::cfg_t cfg_r;
  cwse_pkg::span_wr_t wr;
  cwse_pkg::item_t f_item, q_item;
  logic tbl_ready, push, q_empty, q_full;
  logic [cwse_pkg::EDGE_W-1:0] out_l, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= 10'd100;
      cfg_r.center_x <= 12'd240;
      cfg_r.center_y <= 12'd180;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwse_pkg::REG_RADIUS: cfg_r.radius <= cfg_data[9:0];
        cwse_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_data;
        cwse_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  cwse_span_build u_build (
    .clk(clk), .rst_n(rst_n), .wr(wr), .ready(tbl_ready)
  );

  cwse_front u_front (
    .start(start), .scanline(in_scanline), .cfg(cfg_r), .tbl_ready(tbl_ready),
    .q_full(q_full), .push(push), .item(f_item), .busy(busy)
  );

  cwse_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(f_item), .pop(1'b1),
    .dout(q_item), .empty(q_empty), .full(q_full)
  );

  cwse_back u_back (
    .clk(clk), .rst_n(rst_n), .in_v(!q_empty), .in_item(q_item),
    .radius(cfg_r.radius), .wr(wr), .tbl_ready(tbl_ready), .out_v(out_valid),
    .out_en(out_window_enabled), .out_l(out_l), .out_r(out_r)
  );

  assign out_left_x = $signed(out_l);
  assign out_right_x = $signed(out_r);

  `CWSE_ASSERT(a_busy_in_build, !tbl_ready |-> busy, "request port open during build")
  `CWSE_ASSERT(a_off_is_zero, out_valid && !out_window_enabled |->
    out_left_x == 13'sd0 && out_right_x == 13'sd0, "disabled result with edges")
  `CWSE_ASSERT(a_no_push_full, q_full |-> !push, "push into full queue")
endmodule
